@@ src/kdrd_pkg.sv @@
// Shared types and constants for the key debounce and release dispatch block.
// No dependencies; every other file in src depends on this package.
package kdrd_pkg;

	localparam int NumKeys = 4;
	localparam int KeyW    = 3;
	localparam int CntW    = 8;
	localparam int RegIdxW = 2;
	localparam int CfgDataW = 8;

	localparam logic [CntW-1:0]    TickDividerRst   = 8'd10;
	localparam logic [CntW-1:0]    PollThresholdRst = 8'd20;
	localparam logic [NumKeys-1:0] ActiveLevelsRst  = 4'd0;
	localparam logic [KeyW-1:0]    KeyNone          = 3'd0;
	localparam logic [KeyW-1:0]    KeyMax           = 3'd4;

	typedef enum logic [RegIdxW-1:0] {
		RegTickDivider   = 2'd0,
		RegPollThreshold = 2'd1,
		RegActiveLevels  = 2'd2
	} kdrd_reg_t;

	typedef struct packed {
		logic [CntW-1:0]    tick_divider;
		logic [CntW-1:0]    poll_threshold;
		logic [NumKeys-1:0] active_levels;
	} kdrd_cfg_t;

endpackage

@@ src/kdrd_in_if.sv @@
// Request channel carrying one tick of raw key pin levels.
// Depends on kdrd_pkg for the key count.
interface kdrd_in_if;
	logic                          valid;
	logic                          ready;
	logic [kdrd_pkg::NumKeys-1:0]  pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink   (input valid, input pin_levels, output ready);
endinterface

@@ src/kdrd_out_if.sv @@
// Result channel carrying the reported key number for one tick.
// Depends on kdrd_pkg for the key number width.
interface kdrd_out_if;
	logic                       valid;
	logic                       ready;
	logic [kdrd_pkg::KeyW-1:0]  key_id;

	modport source (output valid, output key_id, input ready);
	modport sink   (input valid, input key_id, output ready);
endinterface

@@ src/kdrd_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on kdrd_pkg for index and data widths.
interface kdrd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kdrd_pkg::RegIdxW-1:0]   index;
	logic [kdrd_pkg::CfgDataW-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/kdrd_cfg_regs.sv @@
// Configuration registers: tick divider, poll threshold, active levels.
// Depends on kdrd_pkg and kdrd_cfg_if.
module kdrd_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	kdrd_cfg_if.sink            cfg,
	output kdrd_pkg::kdrd_cfg_t cfg_regs
);
	import kdrd_pkg::*;

	kdrd_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.tick_divider   <= TickDividerRst;
			regs_q.poll_threshold <= PollThresholdRst;
			regs_q.active_levels  <= ActiveLevelsRst;
		end else if (cfg.valid && cfg.ready) begin
			case (kdrd_reg_t'(cfg.index))
				RegTickDivider:   regs_q.tick_divider   <= cfg.data;
				RegPollThreshold: regs_q.poll_threshold <= cfg.data;
				RegActiveLevels:  regs_q.active_levels  <= cfg.data[NumKeys-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/kdrd_core.sv @@
// Debounce state, prescaler and poll counter; computes the key to report.
// Depends on kdrd_pkg.
module kdrd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kdrd_pkg::kdrd_cfg_t           cfg_regs,
	input  logic                          step,
	input  logic [kdrd_pkg::NumKeys-1:0]  pins,
	output logic [kdrd_pkg::KeyW-1:0]     key_next
);
	import kdrd_pkg::*;

	logic [CntW-1:0]    tick_q, scan_q;
	logic [NumKeys-1:0] seen_q, confirmed_q, pending_q;

	logic [CntW-1:0]    tick_inc, tick_d, scan_d;
	logic [NumKeys-1:0] act, seen_d, confirmed_d, pending_d, pending_scan, clr_mask;
	logic               scan, fire;
	logic [KeyW-1:0]    first_key;

	always_comb begin
		tick_inc    = tick_q + 1'b1;
		scan        = (tick_inc >= cfg_regs.tick_divider);
		act         = ~(pins ^ cfg_regs.active_levels);
		fire        = scan && (scan_q > cfg_regs.poll_threshold);

		pending_scan = pending_q | (confirmed_q & ~act);
		first_key    = KeyNone;
		clr_mask     = '0;
		for (int k = NumKeys - 1; k >= 0; k--) begin
			if (pending_scan[k]) begin
				first_key = KeyW'(k + 1);
				clr_mask  = NumKeys'(1) << k;
			end
		end

		tick_d      = scan ? '0 : tick_inc;
		seen_d      = scan ? act : seen_q;
		confirmed_d = scan ? ((confirmed_q | (seen_q & act)) & act) : confirmed_q;
		pending_d   = !scan ? pending_q : (fire ? (pending_scan & ~clr_mask) : pending_scan);
		scan_d      = !scan ? scan_q : (fire ? '0 : scan_q + 1'b1);
		key_next    = fire ? first_key : KeyNone;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			scan_q      <= '0;
			seen_q      <= '0;
			confirmed_q <= '0;
			pending_q   <= '0;
		end else if (step) begin
			tick_q      <= tick_d;
			scan_q      <= scan_d;
			seen_q      <= seen_d;
			confirmed_q <= confirmed_d;
			pending_q   <= pending_d;
		end
	end

	a_confirmed_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(confirmed_q & ~seen_q) == '0)
		else $error("confirmed press without active sample");

	a_reported_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && key_next != KeyNone |=> (pending_q & $past(clr_mask)) == '0)
		else $error("reported key still pending");

	a_idle_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		!scan |-> key_next == KeyNone)
		else $error("key reported on a tick without a scan");

endmodule

@@ src/key_debounce_release_dispatch.sv @@
// Top level of the key debounce and release dispatch block.
// Depends on kdrd_pkg, kdrd_in_if, kdrd_out_if, kdrd_cfg_if, kdrd_cfg_regs, kdrd_core.
//
// Usage:
//   key_in  : one request per tick, pin_levels holds the four raw key pins.
//   key_out : one request per tick, key_id is 0 or the released key (1 to 4).
//   cfg     : register writes (0 tick_divider, 1 poll_threshold, 2 active_levels),
//             always ready; write only while no tick is in flight.
// Path: an accepted tick passes through the input register, then the result
//   register.
// Throughput: one tick per cycle while key_out is taken; the debounce update,
//   prescaler, poll counter and priority pick settle between input and result registers.
// Reset: arst_n clears the counters, debounce flags and the valid bits of both
//   registers; the configuration returns to divider 10, threshold 20, active levels 0.
// Stall: while key_out is not taken the result register holds, the input
//   register keeps its tick, and key_in drops ready once that register is full.
module key_debounce_release_dispatch (
	input  logic      clk,
	input  logic      arst_n,
	kdrd_in_if.sink   key_in,
	kdrd_out_if.source key_out,
	kdrd_cfg_if.sink  cfg
);
	import kdrd_pkg::*;

	kdrd_cfg_t          cfg_regs;
	logic               valid_s1;
	logic [NumKeys-1:0] pins_s1;
	logic               out_valid_q;
	logic [KeyW-1:0]    key_q;
	logic [KeyW-1:0]    key_next;
	logic               advance;

	assign advance      = valid_s1 && (!out_valid_q || key_out.ready);
	assign key_in.ready = !valid_s1 || advance;
	assign key_out.valid  = out_valid_q;
	assign key_out.key_id = key_q;

	kdrd_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	kdrd_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.step     (advance),
		.pins     (pins_s1),
		.key_next (key_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.valid && key_in.ready) begin
			pins_s1 <= key_in.pin_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || key_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_q <= key_next;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !key_out.ready |=> valid_s1 && $stable(pins_s1))
		else $error("input register lost a tick under stall");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> key_q <= KeyMax)
		else $error("key number out of range");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register empty after advance");

endmodule
